// ----- rtl/fcw_pkg.sv -----
// shared types and constants of the fat12 cluster chain walker
package fcw_pkg;

	// item actions
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_NEXT  = 2'd2;

	// fixed geometry
	localparam int          SectorShift = 9;
	localparam logic [20:0] SectorBytes = 21'd512;
	localparam logic [9:0]  SectorCount = 10'd512;
	localparam int          EntryBits   = 12;

	typedef struct packed {
		logic [1:0]  action;
		logic [23:0] packed_bytes;
		logic [10:0] pair_index;
		logic [11:0] start_cluster;
		logic [20:0] file_size;
	} fcw_req_t;

	typedef struct packed {
		logic        valid_res;
		logic [20:0] byte_offset;
		logic [9:0]  byte_count;
		logic        last;
	} fcw_rsp_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic fetch;
	} fcw_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic chain;
	} fcw_sts_t;

endpackage

// ----- rtl/fcw_ram.sv -----
// generic single write port ram with registered read
module fcw_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 2048,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/fcw_datapath.sv -----
// walker datapath: table banks, chain state and result register
module fcw_datapath import fcw_pkg::*; #(
	parameter int TABLE_ENTRIES = 4096
) (
	input  logic     clk,
	input  logic     arst_n,
	input  fcw_req_t req,
	input  fcw_cmd_t cmd,
	output fcw_sts_t sts,
	output fcw_rsp_t rsp
);

	localparam int EvenDepth = (TABLE_ENTRIES + 1) / 2;
	localparam int OddDepth  = TABLE_ENTRIES / 2;
	localparam int EvenAw    = (EvenDepth > 1) ? $clog2(EvenDepth) : 1;
	localparam int OddAw     = (OddDepth > 1) ? $clog2(OddDepth) : 1;
	localparam logic [12:0] TableLimit = 13'(TABLE_ENTRIES);

	logic [11:0] cluster_q;
	logic [20:0] remaining_q;
	logic        active_q;
	fcw_rsp_t    rsp_q;

	logic [23:0] pb;
	logic [11:0] even_wdata;
	logic [11:0] odd_wdata;
	logic        is_load;
	logic        even_we;
	logic        odd_we;
	logic [11:0] even_rdata;
	logic [11:0] odd_rdata;
	logic [11:0] next_cluster;
	logic        is_next;
	logic        fits_sector;
	fcw_rsp_t    rsp_d;

	// unpack a byte triple into two entries
	assign pb         = req.packed_bytes;
	assign even_wdata = {pb[11:8], pb[7:0]};
	assign odd_wdata  = {pb[23:16], pb[15:12]};
	assign is_load    = cmd.accept && (req.action == ACT_LOAD);
	assign even_we    = is_load && ({1'b0, req.pair_index, 1'b0} < TableLimit);
	assign odd_we     = is_load && ({1'b0, req.pair_index, 1'b1} < TableLimit);

	// even entries and odd entries live in separate banks
	fcw_ram #(.WIDTH(EntryBits), .DEPTH(EvenDepth)) u_even (
		.clk   (clk),
		.we    (even_we),
		.waddr (req.pair_index[EvenAw-1:0]),
		.wdata (even_wdata),
		.raddr (cluster_q[EvenAw:1]),
		.rdata (even_rdata)
	);

	fcw_ram #(.WIDTH(EntryBits), .DEPTH(OddDepth)) u_odd (
		.clk   (clk),
		.we    (odd_we),
		.waddr (req.pair_index[OddAw-1:0]),
		.wdata (odd_wdata),
		.raddr (cluster_q[OddAw:1]),
		.rdata (odd_rdata)
	);

	// chain step target, zero past the table
	always_comb begin
		if ({1'b0, cluster_q} < TableLimit) begin
			next_cluster = cluster_q[0] ? odd_rdata : even_rdata;
		end else begin
			next_cluster = '0;
		end
	end

	// descriptor for the item at hand
	assign is_next     = (req.action == ACT_NEXT) && active_q;
	assign fits_sector = (remaining_q <= SectorBytes);
	assign sts.chain   = is_next && !fits_sector;

	always_comb begin
		rsp_d = '0;
		if (is_next) begin
			rsp_d.valid_res   = 1'b1;
			rsp_d.byte_offset = {cluster_q, {SectorShift{1'b0}}};
			rsp_d.byte_count  = fits_sector ? remaining_q[9:0] : SectorCount;
			rsp_d.last        = fits_sector;
		end
	end

	// walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_q   <= '0;
			remaining_q <= '0;
			active_q    <= 1'b0;
		end else if (cmd.fetch) begin
			cluster_q <= next_cluster;
		end else if (cmd.accept) begin
			if (req.action == ACT_START) begin
				cluster_q   <= req.start_cluster;
				remaining_q <= req.file_size;
				active_q    <= (req.file_size != '0);
			end else if (is_next) begin
				if (fits_sector) begin
					remaining_q <= '0;
					active_q    <= 1'b0;
				end else begin
					remaining_q <= remaining_q - SectorBytes;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

// ----- rtl/fcw_ctrl.sv -----
// walker controller: handshakes and chain fetch sequencing
module fcw_ctrl import fcw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	input  fcw_sts_t sts,
	output fcw_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_FETCH = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   accept;

	// take an item when idle and the result slot frees up
	assign req_stall = (state_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;
	assign cmd.accept = accept;
	assign cmd.fetch  = (state_q == ST_FETCH);
	assign rsp_valid  = rsp_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && sts.chain) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and result slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/fat12_cluster_chain_walker.sv -----
// Walks FAT12 cluster chains and emits one sector descriptor per next item of an active
// walk. Every item gives exactly one result. A next item that steps along the chain is
// followed by a fetch state, in which the registered read of the allocation table banks
// becomes the new current cluster and no item is taken. A result waits in an output
// register, and the next item is taken only while that register is empty or its result is
// claimed in the same cycle. The table needs no clearing after reset; entries must be
// loaded before a walk passes them.
module fat12_cluster_chain_walker import fcw_pkg::*; #(
	parameter int TABLE_ENTRIES = 4096
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  fcw_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output fcw_rsp_t rsp
);

	fcw_cmd_t cmd;
	fcw_sts_t sts;

	// sequencing
	fcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// table and walk state
	fcw_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

	// chain fetch follows its transfer directly
	a_fetch_after_chain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && sts.chain |=> cmd.fetch)
		else $error("chain step not followed by fetch");

	a_fetch_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch |-> $past(cmd.accept) && $past(sts.chain))
		else $error("fetch without chain step");

	a_no_accept_in_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch |-> !cmd.accept)
		else $error("transfer taken during fetch");

	a_result_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> rsp_valid)
		else $error("accepted item left no result");

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench for the fat12 cluster chain walker
module tb_top;
	import fcw_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ACT_NOP = 2'd3;  // unused action, must change nothing
	localparam int ITEM_TARGET = 1870;
	localparam int TAIL_ITEMS = 150;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AT = 500;
	localparam int DRAIN_CYCLES = 20;
	localparam int STILL_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	fcw_req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	fcw_rsp_t rsp;

	fat12_cluster_chain_walker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// clock
	always #10 clk = ~clk;

	// shadow copy of the table and the walk state
	logic [11:0] fat_model [0:4095];
	bit          fat_loaded [0:4095];
	logic [11:0] walk_cluster;
	logic [20:0] walk_left;
	logic        walk_on;

	// items to send and the descriptor each one must produce
	fcw_req_t pending_req [$];
	fcw_rsp_t predicted_desc [$];
	// descriptors of accepted items still owed by the block
	fcw_rsp_t awaited_desc [$];

	int req_seen = 0;
	int rsp_seen = 0;
	int mismatches = 0;

	// one item applied to the shadow state, giving its descriptor
	function automatic fcw_rsp_t walk_step(fcw_req_t r);
		fcw_rsp_t d;
		d = '0;
		case (r.action)
			ACT_LOAD: begin
				fat_model[{r.pair_index, 1'b0}] = {r.packed_bytes[11:8], r.packed_bytes[7:0]};
				fat_model[{r.pair_index, 1'b1}] = {r.packed_bytes[23:16], r.packed_bytes[15:12]};
				fat_loaded[{r.pair_index, 1'b0}] = 1'b1;
				fat_loaded[{r.pair_index, 1'b1}] = 1'b1;
			end
			ACT_START: begin
				walk_cluster = r.start_cluster;
				walk_left = r.file_size;
				walk_on = (r.file_size != '0);
			end
			ACT_NEXT: begin
				if (walk_on) begin
					d.valid_res = 1'b1;
					d.byte_offset = {walk_cluster, 9'b0};
					if (walk_left <= SectorBytes) begin
						d.byte_count = walk_left[9:0];
						d.last = 1'b1;
						walk_left = '0;
						walk_on = 1'b0;
					end else begin
						d.byte_count = SectorCount;
						walk_left = walk_left - SectorBytes;
						walk_cluster = fat_model[walk_cluster];
					end
				end
			end
			default: ;
		endcase
		return d;
	endfunction

	function automatic fcw_req_t rand_req(logic [1:0] act);
		fcw_req_t r;
		r.action = act;
		r.packed_bytes = 24'($urandom);
		r.pair_index = 11'($urandom);
		r.start_cluster = 12'($urandom);
		r.file_size = 21'($urandom);
		return r;
	endfunction

	function automatic fcw_req_t mk_req(logic [1:0] act, logic [23:0] bytes3,
		logic [10:0] pair, logic [11:0] first, logic [20:0] size);
		fcw_req_t r;
		r.action = act;
		r.packed_bytes = bytes3;
		r.pair_index = pair;
		r.start_cluster = first;
		r.file_size = size;
		return r;
	endfunction

	task automatic post_item(fcw_req_t r);
		pending_req.push_back(r);
		predicted_desc.push_back(walk_step(r));
	endtask

	// queue an item; a chain step through an unloaded entry gets that pair loaded first
	task automatic add_item(fcw_req_t r);
		fcw_req_t fill;
		if (r.action == ACT_NEXT && walk_on && walk_left > SectorBytes
			&& !fat_loaded[walk_cluster]) begin
			fill = rand_req(ACT_LOAD);
			fill.pair_index = walk_cluster[11:1];
			// half the time keep links among low clusters so chains revisit entries
			if ($urandom_range(0, 1) == 1)
				fill.packed_bytes = fill.packed_bytes & 24'h03F03F;
			post_item(fill);
		end
		post_item(r);
	endtask

	// start a file and pull sectors from it, sometimes cut short or overrun
	task automatic add_walk();
		fcw_req_t r;
		int shape;
		int steps;
		r = rand_req(ACT_START);
		if ($urandom_range(0, 1) == 1)
			r.start_cluster = 12'($urandom_range(0, 63));
		shape = $urandom_range(0, 9);
		if (shape == 0)
			r.file_size = 21'(SectorBytes * $urandom_range(1, 6));
		else if (shape == 1)
			r.file_size = 21'($urandom_range(1, 512));
		else if (shape != 2)
			r.file_size = 21'($urandom_range(1, 3072));
		// shape 2 keeps a full-range size and is abandoned after a few sectors
		if (shape == 2)
			steps = $urandom_range(1, 5);
		else
			steps = (r.file_size + 511) / 512 + $urandom_range(0, 1);
		if ($urandom_range(0, 9) == 0)
			steps = $urandom_range(0, steps);
		add_item(r);
		repeat (steps) begin
			if ($urandom_range(0, 19) == 0)
				add_item(rand_req(ACT_LOAD));
			add_item(rand_req(ACT_NEXT));
		end
	endtask

	// stimulus, then reset, then wait for the block to drain
	initial begin
		int pick;
		walk_cluster = '0;
		walk_left = '0;
		walk_on = 1'b0;
		for (int i = 0; i < 4096; i++) begin
			fat_model[i] = '0;
			fat_loaded[i] = 1'b0;
		end

		// directed: idle next, unused action, table corners, chain through 0xfff
		add_item(mk_req(ACT_NEXT, '1, '1, '1, '1));
		add_item(mk_req(ACT_NOP, '1, '1, '1, '1));
		add_item(mk_req(ACT_LOAD, 24'hFFFFFF, 11'h7FF, '0, '0));
		add_item(mk_req(ACT_LOAD, 24'h000000, 11'h000, '1, '1));
		add_item(mk_req(ACT_LOAD, 24'hABC123, 11'h001, '0, '1));
		add_item(mk_req(ACT_START, '0, '0, 12'hFFF, 21'd1025));
		repeat (4) add_item(mk_req(ACT_NEXT, '0, '0, '0, '0));
		// empty file
		add_item(mk_req(ACT_START, '1, '1, 12'h000, 21'd0));
		add_item(mk_req(ACT_NEXT, '1, '1, '1, '1));
		// exactly one full sector
		add_item(mk_req(ACT_START, '0, '0, 12'h000, 21'd512));
		add_item(mk_req(ACT_NEXT, '0, '0, '0, '0));
		// largest file, abandoned by a new start
		add_item(mk_req(ACT_START, '0, '0, 12'h001, 21'h1FFFFF));
		repeat (2) add_item(mk_req(ACT_NEXT, '0, '0, '0, '0));
		add_item(mk_req(ACT_START, '0, '0, 12'hFFE, 21'd513));
		repeat (3) add_item(mk_req(ACT_NEXT, '0, '0, '0, '0));
		// single byte at the top cluster
		add_item(mk_req(ACT_START, '0, '0, 12'hFFF, 21'd1));
		add_item(mk_req(ACT_NEXT, '0, '0, '0, '0));

		// random: mostly whole walks, the rest noise
		while (pending_req.size() < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				add_walk();
			else if (pick < 80)
				add_item(rand_req(ACT_LOAD));
			else if (pick < 88)
				add_item(rand_req(ACT_NEXT));
			else if (pick < 93)
				add_item(rand_req(ACT_NOP));
			else begin
				add_item(rand_req(ACT_START));
				add_item(rand_req(ACT_NEXT));
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (req_seen == pending_req.size());
		wait (awaited_desc.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && awaited_desc.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// request driver with random idle bursts, none near the end
	int drive_idx = 0;
	int send_gap = 0;
	int send_quiet = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall)
				drive_idx++;
			if (!req_valid || !req_stall) begin
				if (drive_idx >= pending_req.size()) begin
					req_valid <= 1'b0;
				end else if (pending_req.size() - drive_idx > TAIL_ITEMS
					&& send_gap != 0) begin
					req_valid <= 1'b0;
					send_gap--;
				end else if (pending_req.size() - drive_idx > TAIL_ITEMS && send_quiet == 0
					&& $urandom_range(0, 7) == 0) begin
					req_valid <= 1'b0;
					send_gap = $urandom_range(0, 16);
					send_quiet = $urandom_range(0, 40);
				end else begin
					if (send_quiet != 0)
						send_quiet--;
					req_valid <= 1'b1;
					req <= pending_req[drive_idx];
				end
			end
		end
	end

	// response monitor: records each request transfer, checks each response transfer
	int take_gap = 0;
	int take_quiet = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		fcw_rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				awaited_desc.push_back(predicted_desc[req_seen]);
				req_seen++;
			end

			if (rsp_valid && !rsp_stall) begin
				rsp_seen++;
				if (awaited_desc.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected descriptor: valid=%0b offset=%0d count=%0d last=%0b",
							rsp.valid_res, rsp.byte_offset, rsp.byte_count, rsp.last);
				end else begin
					want = awaited_desc.pop_front();
					if (rsp.valid_res !== want.valid_res || rsp.byte_offset !== want.byte_offset
						|| rsp.byte_count !== want.byte_count || rsp.last !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("descriptor %0d mismatch: expected valid=%0b offset=%0d count=%0d last=%0b, got valid=%0b offset=%0d count=%0d last=%0b",
								rsp_seen - 1, want.valid_res, want.byte_offset, want.byte_count,
								want.last, rsp.valid_res, rsp.byte_offset, rsp.byte_count,
								rsp.last);
					end
				end
			end

			// one long hold-off so the block backs up into its input
			if (hold_left != 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else if (!hold_done && rsp_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				rsp_stall <= 1'b1;
			end else if (pending_req.size() - req_seen <= TAIL_ITEMS) begin
				rsp_stall <= 1'b0;
			end else if (take_gap != 0) begin
				rsp_stall <= 1'b1;
				take_gap--;
			end else if (take_quiet != 0) begin
				rsp_stall <= 1'b0;
				take_quiet--;
			end else if ($urandom_range(0, 7) == 0) begin
				rsp_stall <= 1'b1;
				take_gap = $urandom_range(0, 16);
				take_quiet = $urandom_range(0, 40);
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	int still_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				still_cycles = 0;
			else
				still_cycles++;
			if (still_cycles >= STILL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

endmodule
